// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SFQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define SFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sfq_pkg.sv =====
package sfq_pkg;

    // Command codes
    localparam logic [1:0] CMD_ENQ    = 2'd0;
    localparam logic [1:0] CMD_DEQ    = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EMPTY     = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] value_in;
    } item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value_out;
        logic [4:0]         position;
        logic [4:0]         occupancy;
    } result_t;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic load;         // write key into the cell at the tail index
        logic shift;        // move data one cell toward the head
        logic match_start;  // capture compare against key
        logic match_shift;  // move match flags one cell toward the head
    } cell_ctl_t;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'b01,
        FSM_SCAN = 2'b10
    } fsm_t;

endpackage

// ===== hdl/sfq_cell.sv =====
module sfq_cell
    import sfq_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CW    = 5
)
(
    input  logic               clk,
    input  cell_ctl_t          ctl,
    input  logic [CW-1:0]      count,
    input  logic signed [31:0] key,
    input  logic signed [31:0] nxt_data,
    input  logic               nxt_hit,
    output logic signed [31:0] data,
    output logic               hit
);

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;
    logic               hit_reg;
    logic               hit_next;

    // Load at the tail, or take the neighbor's entry on a dequeue
    always_comb
    begin
        data_next = data_reg;
        if (ctl.load && (count == CW'(INDEX)))
        begin
            data_next = key;
        end
        else if (ctl.shift)
        begin
            data_next = nxt_data;
        end
    end

    // Capture the compare for occupied cells, then pass flags toward the head
    always_comb
    begin
        hit_next = hit_reg;
        if (ctl.match_start)
        begin
            hit_next = (data_reg == key) && (CW'(INDEX) < count);
        end
        else if (ctl.match_shift)
        begin
            hit_next = nxt_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        hit_reg  <= hit_next;
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule

// ===== hdl/searchable_fifo_queue.sv =====
// Searchable FIFO of DEPTH signed 32-bit entries, built as a row of cells
// with the head in cell 0. Enqueue writes the cell at the tail index and
// dequeue shifts every cell one place toward the head, so both return their
// transaction result in the cycle after acceptance and a new item is taken
// the next cycle unless the waiting result is stalled. Search compares all
// cells at once, then shifts the match flags toward the head one cell per
// cycle until the first hit reaches cell 0 or the occupied cells are
// exhausted, and the input stalls meanwhile. A result waiting in the output
// register does not block the next enqueue or dequeue when it is taken in
// the same cycle. Occupancy carries the low 5 bits of the count, position
// those of the 1-based hit index. Entry contents are not cleared by reset.
module searchable_fifo_queue
    import sfq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item_data,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result_data
);

`include "assert_macros.svh"

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] step_reg;
    logic [CW-1:0] step_next;
    fsm_t          state_reg;
    fsm_t          state_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    result_t       out_reg;
    result_t       out_next;

    cell_ctl_t          ctl;
    logic               accept;
    logic               out_free;
    logic signed [31:0] cell_data [DEPTH+1];
    logic               cell_hit  [DEPTH+1];

    // Chain of cells; the slot past the last cell feeds zeros
    assign cell_data[DEPTH] = '0;
    assign cell_hit[DEPTH]  = 1'b0;

    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            sfq_cell #(
                .INDEX (i),
                .CW    (CW)
            ) u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .count    (count_reg),
                .key      (item_data.value_in),
                .nxt_data (cell_data[i+1]),
                .nxt_hit  (cell_hit[i+1]),
                .data     (cell_data[i]),
                .hit      (cell_hit[i])
            );
        end
    endgenerate

    // Handshake
    assign out_free   = !out_valid_reg || !result_stall;
    assign item_stall = (state_reg != FSM_IDLE) || !out_free;
    assign accept     = item_valid && !item_stall;

    // Command decode, scan sequencing and result formation
    always_comb
    begin
        ctl            = '0;
        count_next     = count_reg;
        step_next      = step_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;

        case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    out_next        = '0;
                    out_next.status = STAT_OK;
                    case (item_data.cmd)
                        CMD_ENQ:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                out_next.status = STAT_FULL;
                            end
                            else
                            begin
                                ctl.load   = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            out_valid_next = 1'b1;
                        end
                        CMD_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                out_next.status = STAT_EMPTY;
                            end
                            else
                            begin
                                out_next.value_out = cell_data[0];
                                ctl.shift          = 1'b1;
                                count_next         = count_reg - 1'b1;
                            end
                            out_valid_next = 1'b1;
                        end
                        CMD_SEARCH:
                        begin
                            ctl.match_start = 1'b1;
                            step_next       = '0;
                            state_next      = FSM_SCAN;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                    out_next.occupancy = 5'(count_next);
                end
            end
            FSM_SCAN:
            begin
                if (cell_hit[0] || (step_reg == count_reg))
                begin
                    // Finish once the output register can take the result
                    if (out_free)
                    begin
                        out_next           = '0;
                        out_next.occupancy = 5'(count_reg);
                        if (cell_hit[0])
                        begin
                            out_next.status   = STAT_OK;
                            out_next.position = 5'(step_reg + 1'b1);
                        end
                        else
                        begin
                            out_next.status = STAT_NOT_FOUND;
                        end
                        out_valid_next = 1'b1;
                        state_next     = FSM_IDLE;
                    end
                end
                else
                begin
                    // Advance the match flags one cell toward the head
                    ctl.match_shift = 1'b1;
                    step_next       = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            step_reg      <= '0;
            state_reg     <= FSM_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            step_reg      <= step_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    // Checks
    `SFQ_ASSERT(a_count_bound, count_reg <= CW'(DEPTH), "entry count exceeds depth")
    `SFQ_ASSERT(a_scan_bound, (state_reg != FSM_SCAN) || (step_reg <= count_reg),
        "search scan ran past the occupied cells")
    `SFQ_ASSERT_NEXT(a_enq_count,
        accept && (item_data.cmd == CMD_ENQ) && (count_reg != CW'(DEPTH)),
        count_reg == $past(count_reg) + 1'b1, "enqueue did not advance the count")
    `SFQ_ASSERT_NEXT(a_scan_result,
        (state_reg == FSM_SCAN) && (state_next == FSM_IDLE),
        result_valid && (result_data.status != STAT_FULL) && (result_data.status != STAT_EMPTY),
        "search finished without a search result")

endmodule
